// ===== hw/rtl/bfa_pkg.sv =====
// shared types, codes and constants of the first-free bitmap allocator
`default_nettype none

package bfa_pkg;

    // width of every item number, pool size and count field
    localparam int NUM_W = 14;

    // bitmap storage word and its index width
    localparam int WORD_BITS = 32;
    localparam int WORD_LG   = 5;

    // pool size after reset
    localparam logic [NUM_W-1:0] POOL_RESET = 14'd8192;

    // request commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // request word
    typedef struct packed {
        logic             cmd;
        logic [NUM_W-1:0] item_number;
    } req_t;

    // response word
    typedef struct packed {
        logic [1:0]       status;
        logic [NUM_W-1:0] allocated_number;
        logic [NUM_W-1:0] free_count;
    } rsp_t;

    // operation class decided at the front
    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_REJECT
    } op_kind_t;

    // queued operation, index is zero-based
    typedef struct packed {
        op_kind_t         kind;
        logic [NUM_W-1:0] index;
    } op_t;

    // head of the operation queue as seen by the back end
    typedef struct packed {
        logic valid;
        op_t  op;
    } op_head_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bfa_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none

module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bfa_front.sv =====
// request intake: range check, classification and a two-entry operation queue
`default_nettype none

module bfa_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_valid,
    output logic                          req_ready,
    input  wire bfa_pkg::req_t            req,
    input  wire logic                     enable,
    input  wire logic [bfa_pkg::NUM_W-1:0] pool_eff,
    output bfa_pkg::op_head_t             head,
    input  wire logic                     pop
);

    import bfa_pkg::*;

    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    op_t        slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    op_t        op_new;
    logic       push;

    // classify the incoming word
    always_comb
    begin
        op_new.index = req.item_number - NUM_W'(1);
        if (req.cmd == CMD_ALLOC)
        begin
            op_new.kind = OP_ALLOC;
        end
        else if (req.item_number == '0 || req.item_number > pool_eff)
        begin
            op_new.kind = OP_REJECT;
        end
        else
        begin
            op_new.kind = OP_FREE;
        end
    end

    assign req_ready  = enable && (fill_reg != QUEUE_DEPTH);
    assign push       = req_valid && req_ready;
    assign head.valid = (fill_reg != 2'd0);
    assign head.op    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 2'd1;
                2'b01:   fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= op_new;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bfa_back.sv =====
// allocation engine: bitmap and full-word summary rams, sequencer, response register
`default_nettype none

module bfa_back #(
    parameter int MAP_BITS = 8192
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire bfa_pkg::op_head_t         head,
    output logic                           pop,
    output logic                           clear_done,
    input  wire logic [bfa_pkg::NUM_W-1:0] pool_eff,
    output logic                           rsp_valid,
    input  wire logic                      rsp_ready,
    output bfa_pkg::rsp_t                  rsp
);

    import bfa_pkg::*;

    localparam int NWORDS  = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int NGROUPS = (NWORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int GADDR_W = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
    localparam int IDX_W   = WADDR_W + WORD_LG;
    localparam int ROW_W   = GADDR_W + 2 * WORD_LG;
    localparam int CMP_A   = (ROW_W > IDX_W) ? ROW_W : IDX_W;
    localparam int CMP_W   = ((CMP_A > NUM_W) ? CMP_A : NUM_W) + 1;
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NWORDS - 1);
    localparam logic [WADDR_W:0]   GROUP_END = (WADDR_W + 1)'(NGROUPS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_ROW,
        S_ALLOC_WORD,
        S_FREE_RMW
    } state_t;

    function automatic logic [WORD_LG-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [WORD_LG-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                pos = WORD_LG'(i);
            end
        end
        return pos;
    endfunction

    state_t               state_reg;
    state_t               state_next;
    logic [WADDR_W-1:0]   clr_cnt_reg;
    logic [NGROUPS-1:0]   grp_full_reg;
    logic [NUM_W-1:0]     used_cnt_reg;
    logic [NUM_W-1:0]     used_cnt_next;
    logic [WADDR_W-1:0]   cur_word_reg;
    logic [WORD_LG-1:0]   cur_bit_reg;
    logic [GADDR_W-1:0]   cur_grp_reg;
    logic [WORD_LG-1:0]   cur_row_bit_reg;
    logic [WORD_BITS-1:0] row_data_reg;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;

    // ram ports
    logic                 map_we;
    logic [WADDR_W-1:0]   map_waddr;
    logic [WORD_BITS-1:0] map_wdata;
    logic [WADDR_W-1:0]   map_raddr;
    logic [WORD_BITS-1:0] map_rdata;
    logic                 sum_we;
    logic [GADDR_W-1:0]   sum_waddr;
    logic [WORD_BITS-1:0] sum_wdata;
    logic [GADDR_W-1:0]   sum_raddr;
    logic [WORD_BITS-1:0] sum_rdata;

    // queue head decode
    logic [IDX_W-1:0]     e_idx;
    logic [WADDR_W-1:0]   e_word;
    logic [WORD_LG-1:0]   e_bit;
    logic [GADDR_W-1:0]   e_grp;
    logic [WORD_LG-1:0]   e_row_bit;

    // search results
    logic                 grp_found;
    logic [GADDR_W-1:0]   grp_first;
    logic [WORD_LG-1:0]   row_zero;
    logic [GADDR_W+WORD_LG-1:0] alloc_word;
    logic                 past_pool;
    logic [WORD_LG-1:0]   word_zero;
    logic [IDX_W-1:0]     new_idx;
    logic                 hit;
    logic [WORD_BITS-1:0] set_word;
    logic [WORD_BITS-1:0] set_row;

    logic                 fire;
    logic [1:0]           res_status;
    logic [NUM_W-1:0]     res_given;
    logic                 grp_set;
    logic                 grp_clr;

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NGROUPS)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    assign e_idx     = IDX_W'(head.op.index);
    assign e_word    = WADDR_W'(e_idx >> WORD_LG);
    assign e_bit     = e_idx[WORD_LG-1:0];
    assign e_grp     = GADDR_W'(e_word >> WORD_LG);
    assign e_row_bit = WORD_LG'(e_word);

    // lowest group that still has a non-full word
    always_comb
    begin
        grp_found = 1'b0;
        grp_first = '0;
        for (int i = NGROUPS - 1; i >= 0; i--)
        begin
            if (!grp_full_reg[i])
            begin
                grp_found = 1'b1;
                grp_first = GADDR_W'(i);
            end
        end
    end

    assign row_zero   = lowest_zero(sum_rdata);
    assign alloc_word = {cur_grp_reg, row_zero};
    assign past_pool  = CMP_W'({alloc_word, {WORD_LG{1'b0}}}) >= CMP_W'(pool_eff);
    assign word_zero  = lowest_zero(map_rdata);
    assign new_idx    = {cur_word_reg, word_zero};
    assign hit        = CMP_W'(new_idx) < CMP_W'(pool_eff);
    assign set_word   = map_rdata | (WORD_BITS'(1) << word_zero);
    assign set_row    = row_data_reg | (WORD_BITS'(1) << cur_row_bit_reg);

    always_comb
    begin
        state_next    = state_reg;
        used_cnt_next = used_cnt_reg;
        pop           = 1'b0;
        fire          = 1'b0;
        res_status    = ST_OK;
        res_given     = '0;
        grp_set       = 1'b0;
        grp_clr       = 1'b0;
        map_we        = 1'b0;
        map_waddr     = cur_word_reg;
        map_wdata     = '0;
        map_raddr     = '0;
        sum_we        = 1'b0;
        sum_waddr     = cur_grp_reg;
        sum_wdata     = '0;
        sum_raddr     = '0;
        case (state_reg)
            S_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_cnt_reg;
                sum_we    = ({1'b0, clr_cnt_reg} < GROUP_END);
                sum_waddr = GADDR_W'(clr_cnt_reg);
                if (clr_cnt_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (head.valid && !rsp_valid_reg)
                begin
                    pop = 1'b1;
                    case (head.op.kind)
                        OP_ALLOC:
                        begin
                            if (grp_found)
                            begin
                                sum_raddr  = grp_first;
                                state_next = S_ALLOC_ROW;
                            end
                            else
                            begin
                                fire       = 1'b1;
                                res_status = ST_FULL;
                            end
                        end
                        OP_FREE:
                        begin
                            map_raddr  = e_word;
                            sum_raddr  = e_grp;
                            state_next = S_FREE_RMW;
                        end
                        default:
                        begin
                            fire       = 1'b1;
                            res_status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_ALLOC_ROW:
            begin
                if (past_pool)
                begin
                    fire       = 1'b1;
                    res_status = ST_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    map_raddr  = WADDR_W'(alloc_word);
                    state_next = S_ALLOC_WORD;
                end
            end
            S_ALLOC_WORD:
            begin
                fire       = 1'b1;
                state_next = S_IDLE;
                if (hit)
                begin
                    map_we        = 1'b1;
                    map_wdata     = set_word;
                    used_cnt_next = used_cnt_reg + NUM_W'(1);
                    res_given     = NUM_W'(CMP_W'(new_idx) + CMP_W'(1));
                    if (&set_word)
                    begin
                        sum_we    = 1'b1;
                        sum_wdata = set_row;
                        grp_set   = &set_row;
                    end
                end
                else
                begin
                    res_status = ST_FULL;
                end
            end
            S_FREE_RMW:
            begin
                fire      = 1'b1;
                grp_clr   = 1'b1;
                map_we    = 1'b1;
                map_wdata = map_rdata & ~(WORD_BITS'(1) << cur_bit_reg);
                sum_we    = 1'b1;
                sum_wdata = sum_rdata & ~(WORD_BITS'(1) << cur_row_bit_reg);
                if (used_cnt_reg != '0)
                begin
                    used_cnt_next = used_cnt_reg - NUM_W'(1);
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            grp_full_reg    <= '0;
            used_cnt_reg    <= '0;
            cur_word_reg    <= '0;
            cur_bit_reg     <= '0;
            cur_grp_reg     <= '0;
            cur_row_bit_reg <= '0;
            row_data_reg    <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_reg         <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            used_cnt_reg <= used_cnt_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + WADDR_W'(1);
            end
            if (pop)
            begin
                cur_word_reg    <= e_word;
                cur_bit_reg     <= e_bit;
                cur_row_bit_reg <= e_row_bit;
                cur_grp_reg     <= (head.op.kind == OP_ALLOC) ? grp_first : e_grp;
            end
            if (state_reg == S_ALLOC_ROW)
            begin
                cur_word_reg    <= WADDR_W'(alloc_word);
                cur_row_bit_reg <= row_zero;
                row_data_reg    <= sum_rdata;
            end
            if (grp_set)
            begin
                grp_full_reg[cur_grp_reg] <= 1'b1;
            end
            if (grp_clr)
            begin
                grp_full_reg[cur_grp_reg] <= 1'b0;
            end
            if (fire)
            begin
                rsp_valid_reg            <= 1'b1;
                rsp_reg.status           <= res_status;
                rsp_reg.allocated_number <= res_given;
                rsp_reg.free_count       <= (pool_eff > used_cnt_next) ?
                                            pool_eff - used_cnt_next : '0;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign clear_done = (state_reg != S_CLEAR);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_first_free_allocator.sv =====
// top level of the first-free bitmap allocator
//
// requests come in on req (valid/ready): an allocate takes the lowest free
// item below the pool size, a free returns a one-based item number
// one response word per request leaves on rsp (valid/ready) in request order,
// with status, the number given out and the free count after the request
// the pool size register is written through cfg_we/cfg_wdata, which the user
// must do only while idle, as the block does not enforce it; sizes above the
// map are clamped to MAP_BITS
// a two-entry queue sits between the intake and the engine, so requests are
// taken while a response is still waiting
// out-of-range frees and allocates with every map word full are answered from
// the idle state, frees from the free state, allocates whose first open word
// lies past the pool from the row state, other allocates from the word state
// the single engine takes a new request only once the response slot is empty
// after reset the bitmap and summary rams are cleared one word per cycle,
// ceil(MAP_BITS/32) map words (256 at the default), with req_ready held low
// when rsp is stalled the engine stops, the queue fills and req_ready drops
`default_nettype none

module bitmap_first_free_allocator #(
    parameter int MAP_BITS = 8192
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_ready,
    input  wire bfa_pkg::req_t             req,
    output logic                           rsp_valid,
    input  wire logic                      rsp_ready,
    output bfa_pkg::rsp_t                  rsp,
    input  wire logic                      cfg_we,
    input  wire logic [bfa_pkg::NUM_W-1:0] cfg_wdata
);

    import bfa_pkg::*;

    // largest pool the map can hold, limited to what the fields can express
    localparam int NUM_MAX = (1 << NUM_W) - 1;
    localparam logic [NUM_W-1:0] MAP_CLAMP = NUM_W'((MAP_BITS > NUM_MAX) ? NUM_MAX : MAP_BITS);

    logic [NUM_W-1:0] pool_size_reg;
    logic [NUM_W-1:0] pool_eff;
    op_head_t         head;
    logic             pop;
    logic             clear_done;

    // pool size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg <= POOL_RESET;
        end
        else if (cfg_we)
        begin
            pool_size_reg <= cfg_wdata;
        end
    end

    // effective pool never exceeds the bitmap
    assign pool_eff = (pool_size_reg > MAP_CLAMP) ? MAP_CLAMP : pool_size_reg;

    // intake: range check and operation queue
    bfa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .enable    (clear_done),
        .pool_eff  (pool_eff),
        .head      (head),
        .pop       (pop)
    );

    // engine: summary search, bitmap update, counters, response register
    bfa_back #(
        .MAP_BITS (MAP_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .clear_done (clear_done),
        .pool_eff   (pool_eff),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

// ===== bench/bitmap_first_free_allocator_test.sv =====
// self-checking testbench of the first-free bitmap allocator
module bitmap_first_free_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bfa_pkg::*;

    localparam int MAP_BITS    = 8192;
    localparam int RANDOM_WORDS = 1250;
    localparam int MAX_REPORTS  = 50;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // request side
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;

    // response side
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // pool size register port
    logic cfg_we = 1'b0;
    logic [NUM_W-1:0] cfg_wdata = '0;

    // requests waiting to be driven and responses still owed by the block
    req_t pending_reqs[$];
    rsp_t awaited_rsps[$];

    // progress counters, only ever incremented, so idle checks never race
    int unsigned n_queued = 0;
    int unsigned n_taken = 0;
    int unsigned n_returned = 0;
    int unsigned mismatch_count = 0;

    // per-word gap on the request side and stall on the response side
    int unsigned tx_gap;
    int unsigned rx_stall;
    int unsigned rx_next;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;

    // allocator state as the testbench predicts it
    bit used_map[MAP_BITS];
    int unsigned used_count = 0;
    logic [NUM_W-1:0] pool_setting = POOL_RESET;

    always #4 clk = ~clk;

    bitmap_first_free_allocator #(
        .MAP_BITS(MAP_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // pool size as the block uses it: the register clamped to the map
    function automatic int unsigned eff_pool();
        return (pool_setting > MAP_BITS) ? MAP_BITS : int'(pool_setting);
    endfunction

    // advance the predicted state by one request and return the response it owes
    function automatic rsp_t serve_request(req_t r);
        int unsigned pool;
        rsp_t o;
        pool = eff_pool();
        o.status = ST_OK;
        o.allocated_number = '0;
        if (r.cmd == CMD_ALLOC)
        begin
            // first fit over the managed part of the map only
            o.status = ST_FULL;
            for (int i = 0; i < pool; i++)
            begin
                if (!used_map[i])
                begin
                    used_map[i] = 1'b1;
                    used_count++;
                    o.allocated_number = NUM_W'(i + 1);
                    o.status = ST_OK;
                    break;
                end
            end
        end
        else if (r.item_number == 0 || r.item_number > pool)
        begin
            o.status = ST_RANGE;
        end
        else
        begin
            // a free of a clear bit still takes one from the count
            used_map[r.item_number - 1] = 1'b0;
            if (used_count > 0)
                used_count--;
        end
        o.free_count = (pool > used_count) ? NUM_W'(pool - used_count) : '0;
        return o;
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("error: response %0d %s got %0d expected %0d",
                     n_returned, field, got, want);
    endtask

    // request driver: one word at a time, random gap before each new word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            tx_gap <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                awaited_rsps.push_back(serve_request(req));
                n_taken++;
            end
            // the slot is free once the current word is taken or none is up
            if (!req_valid || req_ready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap <= tx_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    tx_gap <= tx_burst ? 0 : $urandom_range(0, 4);
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor: compares each word with the oldest expectation,
    // then stalls for a random number of cycles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rx_stall <= 0;
        end
        else
        begin
            rx_next = rx_stall;
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_rsps.size() == 0)
                begin
                    report_mismatch("unexpected word", 1, 0);
                end
                else
                begin
                    rsp_t want;
                    want = awaited_rsps.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.allocated_number !== want.allocated_number)
                        report_mismatch("allocated_number", rsp.allocated_number,
                                        want.allocated_number);
                    if (rsp.free_count !== want.free_count)
                        report_mismatch("free_count", rsp.free_count, want.free_count);
                end
                n_returned++;
                rx_next = rx_burst ? 0 : $urandom_range(0, 4);
            end
            else if (rx_next != 0)
            begin
                rx_next = rx_next - 1;
            end
            rx_stall <= rx_next;
            rsp_ready <= (rx_next == 0);
        end
    end

    task automatic queue_req(logic cmd, int unsigned num);
        req_t r;
        r.cmd = cmd;
        r.item_number = NUM_W'(num);
        pending_reqs.push_back(r);
        n_queued++;
    endtask

    // block until every queued word is taken and answered
    task automatic wait_idle();
        while (n_taken != n_queued || n_returned != n_taken)
            @(posedge clk);
    endtask

    // pool size writes happen only with nothing in flight
    task automatic set_pool(int unsigned value);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= NUM_W'(value);
        pool_setting = NUM_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // a currently used one-based number inside the pool, 0 if there is none
    function automatic int unsigned pick_used();
        int unsigned pool;
        int unsigned start;
        pool = eff_pool();
        if (pool == 0)
            return 0;
        start = $urandom_range(0, pool - 1);
        for (int k = 0; k < pool; k++)
        begin
            if (used_map[(start + k) % pool])
                return ((start + k) % pool) + 1;
        end
        return 0;
    endfunction

    // one random phase: mostly allocs and frees of live numbers, some noise
    task automatic run_phase(int unsigned n, int unsigned alloc_pct);
        int unsigned pool;
        int unsigned num;
        int unsigned r;
        for (int k = 0; k < n; k++)
        begin
            // keep at most three words ahead so frees see fresh state
            while (n_queued - n_taken > 2)
                @(posedge clk);
            // now and then the sender holds off until all answers are in
            if ($urandom_range(0, 39) == 0)
                wait_idle();
            pool = eff_pool();
            if ($urandom_range(0, 99) < alloc_pct)
            begin
                // number field is don't-care on allocate, so randomize it fully
                queue_req(CMD_ALLOC, $urandom_range(0, 16383));
            end
            else
            begin
                r = $urandom_range(0, 9);
                if (r <= 6)
                begin
                    num = pick_used();
                    if (num == 0)
                        num = (pool == 0) ? 1 : $urandom_range(1, pool);
                end
                else if (r == 7)
                    num = $urandom_range(0, 16383);
                else if (r == 8)
                    num = (pool == 0) ? 0 : $urandom_range(1, pool);
                else
                    num = $urandom_range(0, 1) ? 0 : pool + 1;
                queue_req(CMD_FREE, num);
            end
        end
    endtask

    initial
    begin
        int unsigned random_sent;
        int unsigned pick;
        int unsigned value;
        int unsigned pcts[3];
        pcts = '{20, 50, 80};
        random_sent = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: default pool of 8192, first fit and refill of a hole
        queue_req(CMD_ALLOC, 0);
        queue_req(CMD_ALLOC, 16383);
        queue_req(CMD_ALLOC, 0);
        queue_req(CMD_FREE, 2);
        queue_req(CMD_ALLOC, 0);
        // number zero and numbers past the pool are rejected
        queue_req(CMD_FREE, 0);
        queue_req(CMD_FREE, 8193);
        queue_req(CMD_FREE, 16383);
        // free of a clear bit at the top of the map still drops the count
        queue_req(CMD_FREE, 8192);
        // repeated frees run the count down and hold it at zero
        queue_req(CMD_FREE, 3);
        queue_req(CMD_FREE, 3);
        queue_req(CMD_FREE, 3);

        // empty pool: nothing to give, every number out of range
        set_pool(0);
        queue_req(CMD_ALLOC, 0);
        queue_req(CMD_FREE, 1);

        // register above the map, clamped to the map size
        set_pool(16383);
        queue_req(CMD_ALLOC, 0);
        queue_req(CMD_FREE, 8192);

        // small pool filled up, then a number just past it
        set_pool(4);
        queue_req(CMD_ALLOC, 0);
        queue_req(CMD_ALLOC, 0);
        queue_req(CMD_FREE, 5);
        set_pool(8);
        queue_req(CMD_ALLOC, 0);
        queue_req(CMD_ALLOC, 0);

        // pool shrunk under set bits: free count pinned at zero, upper bits stuck
        set_pool(1);
        queue_req(CMD_ALLOC, 0);
        queue_req(CMD_FREE, 2);
        queue_req(CMD_FREE, 1);

        // random phases with a fresh pool size and idling mix each time
        while (random_sent < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                value = 0;
            else if (pick == 1)
                value = MAP_BITS;
            else if (pick == 2)
                value = $urandom_range(MAP_BITS + 1, 16383);
            else if (pick <= 5)
                value = $urandom_range(65, 600);
            else
                value = $urandom_range(1, 64);
            set_pool(value);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(60, 160);
            run_phase(pick, pcts[$urandom_range(0, 2)]);
            random_sent += pick;
        end

        // drain and give stray words time to show up
        wait_idle();
        repeat (20) @(posedge clk);
        if (awaited_rsps.size() != 0)
            report_mismatch("missing words", 0, awaited_rsps.size());
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
